/* hdl/multi_lamp_blink_controller_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the lamp blink controller
// Shared property wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_LAMP_BLINK_CONTROLLER_CORE_MACROS_SVH
`define MULTI_LAMP_BLINK_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication
`define MLBC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mlbc: same-cycle check failed");

// Next-cycle implication
`define MLBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mlbc: next-cycle check failed");

`endif

/* hdl/mlbc_pkg.sv */
// ----------------------------------------------------------------------------
// mlbc_pkg
// Types and constants of the lamp blink controller.
// ----------------------------------------------------------------------------
package mlbc_pkg;

  localparam int MaxGroupsDefault = 8;
  localparam int LampsPerGroup    = 3;
  localparam int LevelW           = 24;
  localparam int GroupW           = 4;
  localparam int LampIdxW         = 2;
  localparam int ModeCodeW        = 3;
  localparam int StatusW          = 3;
  localparam int DivW             = 8;
  localparam int CfgIdxW          = 2;
  localparam int CfgDataW         = 8;
  // lamp select: group*3 + lamp, up to 15*3+3
  localparam int SelW             = 6;

  localparam logic [GroupW-1:0] GroupCountReset = 4'd8;
  localparam logic [DivW-1:0]   DivisorReset    = 8'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GROUP_COUNT  = 2'd0,
    CFG_SLOW_DIVISOR = 2'd1,
    CFG_SPARE_2      = 2'd2,
    CFG_SPARE_3      = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_SLOW = 2'd2,
    MODE_FAST = 2'd3
  } lamp_mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NO_GROUPS = 3'd1,
    ST_BAD_GROUP = 3'd2,
    ST_BAD_LAMP  = 3'd3,
    ST_BAD_MODE  = 3'd4
  } status_e;

  // Lamp write command from the checker to the lamp bank
  typedef struct packed {
    logic            ok;
    lamp_mode_e      mode;
    logic [SelW-1:0] sel;
  } set_cmd_t;

endpackage

/* hdl/mlbc_set_check.sv */
// ----------------------------------------------------------------------------
// mlbc_set_check
// Validates a set word and forms the lamp write command.
// ----------------------------------------------------------------------------
module mlbc_set_check (
  input  logic [mlbc_pkg::GroupW-1:0]    groups_in_use_i,
  input  logic [mlbc_pkg::GroupW-1:0]    group_index_i,
  input  logic [mlbc_pkg::LampIdxW-1:0]  lamp_index_i,
  input  logic [mlbc_pkg::ModeCodeW-1:0] mode_code_i,
  output mlbc_pkg::status_e              status_o,
  output mlbc_pkg::set_cmd_t             cmd_o
);
  import mlbc_pkg::*;

  // Checks in priority order
  always_comb begin
    priority if (groups_in_use_i == '0) begin
      status_o = ST_NO_GROUPS;
    end else if (group_index_i >= groups_in_use_i) begin
      status_o = ST_BAD_GROUP;
    end else if (lamp_index_i == 2'd3) begin
      status_o = ST_BAD_LAMP;
    end else if (mode_code_i[2]) begin
      status_o = ST_BAD_MODE;
    end else begin
      status_o = ST_OK;
    end
  end

  // Flat lamp number: group*3 + lamp
  always_comb begin
    cmd_o.ok   = (status_o == ST_OK);
    cmd_o.mode = lamp_mode_e'(mode_code_i[1:0]);
    cmd_o.sel  = ({2'b00, group_index_i} << 1) + {2'b00, group_index_i}
                 + {{(SelW-LampIdxW){1'b0}}, lamp_index_i};
  end

endmodule

/* hdl/mlbc_lamp_bank.sv */
// ----------------------------------------------------------------------------
// mlbc_lamp_bank
// Lamp mode/phase registers, slow prescaler and lit-level decode.
// ----------------------------------------------------------------------------
module mlbc_lamp_bank #(
  parameter int MAX_GROUPS = mlbc_pkg::MaxGroupsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         tick_i,
  input  logic                         set_i,
  input  mlbc_pkg::set_cmd_t           cmd_i,
  input  logic [mlbc_pkg::GroupW-1:0]  groups_in_use_i,
  input  logic [mlbc_pkg::DivW-1:0]    slow_divisor_i,
  output logic [mlbc_pkg::LevelW-1:0]  levels_d_o
);
  import mlbc_pkg::*;

  localparam int LampTotal = MAX_GROUPS * LampsPerGroup;

  lamp_mode_e        mode_q  [LampTotal];
  lamp_mode_e        mode_d  [LampTotal];
  logic              phase_q [LampTotal];
  logic              phase_d [LampTotal];
  logic [DivW-1:0]   presc_q, presc_d;
  logic [DivW-1:0]   div_eff;
  logic [DivW:0]     presc_inc;

  // Prescaler: divisor zero acts as one
  always_comb begin
    div_eff   = (slow_divisor_i == '0) ? {{(DivW-1){1'b0}}, 1'b1} : slow_divisor_i;
    presc_inc = {1'b0, presc_q} + {{DivW{1'b0}}, 1'b1};
    presc_d   = presc_q;
    if (tick_i) begin
      presc_d = (presc_inc >= {1'b0, div_eff}) ? '0 : presc_inc[DivW-1:0];
    end
  end

  // Per-lamp next state; unused groups hold on a tick
  always_comb begin
    for (int k = 0; k < LampTotal; k++) begin
      mode_d[k]  = mode_q[k];
      phase_d[k] = phase_q[k];
      if (tick_i && ((k / LampsPerGroup) < int'(groups_in_use_i))) begin
        if (mode_q[k] == MODE_FAST) begin
          phase_d[k] = ~phase_q[k];
        end else if (mode_q[k] == MODE_SLOW && presc_d == '0) begin
          phase_d[k] = ~phase_q[k];
        end
      end
      if (set_i && cmd_i.ok && (cmd_i.sel == SelW'(k))) begin
        mode_d[k]  = cmd_i.mode;
        phase_d[k] = (cmd_i.mode == MODE_SLOW) || (cmd_i.mode == MODE_FAST);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q <= '0;
      for (int k = 0; k < LampTotal; k++) begin
        mode_q[k]  <= MODE_OFF;
        phase_q[k] <= 1'b0;
      end
    end else begin
      presc_q <= presc_d;
      for (int k = 0; k < LampTotal; k++) begin
        mode_q[k]  <= mode_d[k];
        phase_q[k] <= phase_d[k];
      end
    end
  end

  // Lit levels after this word's update, masked to groups in use
  for (genvar k = 0; k < LevelW; k++) begin : g_level
    if (k < LampTotal) begin : g_lamp
      assign levels_d_o[k] = ((k / LampsPerGroup) < int'(groups_in_use_i)) &&
                             ((mode_d[k] == MODE_ON) ||
                              (((mode_d[k] == MODE_SLOW) || (mode_d[k] == MODE_FAST))
                               && phase_d[k]));
    end else begin : g_none
      assign levels_d_o[k] = 1'b0;
    end
  end

endmodule

/* hdl/multi_lamp_blink_controller_core.sv */
// ----------------------------------------------------------------------------
// multi_lamp_blink_controller_core
// Tick/set word in, status plus all lamp levels out, one result per word.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------
//   in      | in_valid_i / in_ready_o | func, group_index, lamp_index, mode
//   out     | out_valid_o/out_ready_i | status, lamp_levels
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A word is held in the input register, then the lamp update and result are
// registered together; one word per cycle while the result is not stalled.
// Lamp state is written on the same edge as the result, so words can follow
// back to back. A stalled result holds both registers; the input side
// accepts again once the result register frees. Reset clears all lamps.
// ----------------------------------------------------------------------------
module multi_lamp_blink_controller_core #(
  parameter int MAX_GROUPS = mlbc_pkg::MaxGroupsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic [mlbc_pkg::GroupW-1:0]     group_index_i,
  input  logic [mlbc_pkg::LampIdxW-1:0]   lamp_index_i,
  input  logic [mlbc_pkg::ModeCodeW-1:0]  mode_code_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mlbc_pkg::StatusW-1:0]    status_o,
  output logic [mlbc_pkg::LevelW-1:0]     lamp_levels_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mlbc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mlbc_pkg::CfgDataW-1:0]   cfg_data_i
);
  import mlbc_pkg::*;

  `include "multi_lamp_blink_controller_core_macros.svh"

  logic [GroupW-1:0]    group_count_q;
  logic [DivW-1:0]      slow_divisor_q;
  logic [GroupW-1:0]    groups_in_use;

  logic                 in_valid_q;
  logic                 func_q;
  logic [GroupW-1:0]    group_q;
  logic [LampIdxW-1:0]  lamp_q;
  logic [ModeCodeW-1:0] mode_q;

  logic                 out_valid_q;
  status_e              status_q;
  logic [LevelW-1:0]    levels_q;

  logic                 advance;
  status_e              chk_status;
  set_cmd_t             set_cmd;
  logic [LevelW-1:0]    levels_d;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_count_q  <= GroupCountReset;
      slow_divisor_q <= DivisorReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_GROUP_COUNT:  group_count_q  <= cfg_data_i[GroupW-1:0];
        CFG_SLOW_DIVISOR: slow_divisor_q <= cfg_data_i[DivW-1:0];
        default: ;
      endcase
    end
  end

  // Group count clamped to the built size
  assign groups_in_use = (int'(group_count_q) < MAX_GROUPS) ? group_count_q
                                                            : GroupW'(MAX_GROUPS);

  // Pipeline control
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      func_q  <= func_i;
      group_q <= group_index_i;
      lamp_q  <= lamp_index_i;
      mode_q  <= mode_code_i;
    end
  end

  mlbc_set_check u_check (
    .groups_in_use_i (groups_in_use),
    .group_index_i   (group_q),
    .lamp_index_i    (lamp_q),
    .mode_code_i     (mode_q),
    .status_o        (chk_status),
    .cmd_o           (set_cmd)
  );

  mlbc_lamp_bank #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_bank (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tick_i          (advance && !func_q),
    .set_i           (advance && func_q),
    .cmd_i           (set_cmd),
    .groups_in_use_i (groups_in_use),
    .slow_divisor_i  (slow_divisor_q),
    .levels_d_o      (levels_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= func_q ? chk_status : ST_OK;
      levels_q <= levels_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign lamp_levels_o = levels_q;

  // Checks
  `MLBC_ASSERT_NEXT(a_tick_ok, advance && !func_q, status_q == ST_OK)
  `MLBC_ASSERT_IMPL(a_stall_cause, !in_ready_o, in_valid_q && out_valid_q && !out_ready_i)
  `MLBC_ASSERT_NEXT(a_hold_word, in_valid_q && out_valid_q && !out_ready_i, in_valid_q)

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: lamp blink controller testbench
// Sends tick and lamp-set words through the input channel and writes the
// group count and slow divisor between phases. A local model of the lamp
// bank predicts status and lamp levels for every word, and the scoreboard
// compares each result in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mlbc_pkg::*;

  localparam int Groups    = MaxGroupsDefault;
  localparam int LampCount = Groups * LampsPerGroup;
  localparam int IdleLimit = 500;

  localparam logic                 FuncTick    = 1'b0;
  localparam logic                 FuncSet     = 1'b1;
  localparam logic [LampIdxW-1:0]  LampBad     = 2'd3;
  localparam logic [ModeCodeW-1:0] ModeBadLow  = 3'd4;
  localparam logic [ModeCodeW-1:0] ModeBadHigh = 3'd7;

  typedef struct {
    status_e           status;
    logic [LevelW-1:0] levels;
  } lamp_result_t;

  // DUT ports
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 func_i = 1'b0;
  logic [GroupW-1:0]    group_index_i = '0;
  logic [LampIdxW-1:0]  lamp_index_i = '0;
  logic [ModeCodeW-1:0] mode_code_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [StatusW-1:0]   status_o;
  logic [LevelW-1:0]    lamp_levels_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  // Lamp bank model
  lamp_mode_e      mode_q [LampCount];
  logic            phase_q [LampCount];
  logic [DivW-1:0] prescaler_q;
  logic [GroupW-1:0] group_count_q;
  logic [DivW-1:0] divisor_q;

  lamp_result_t expected_q [$];

  bit no_idle = 1'b0;
  int error_count = 0;
  int words_sent = 0;
  int ticks_seen = 0;
  int sets_seen = 0;
  int sets_rejected = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;

  multi_lamp_blink_controller_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .group_index_i (group_index_i),
    .lamp_index_i  (lamp_index_i),
    .mode_code_i   (mode_code_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .lamp_levels_o (lamp_levels_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Lamp bank model
  // ---------------------------------------------------------------------------
  function automatic int groups_used();
    return (group_count_q > Groups) ? Groups : int'(group_count_q);
  endfunction

  function automatic logic [LevelW-1:0] lit_levels();
    logic [LevelW-1:0] lv;
    int n;
    lv = '0;
    n = groups_used() * LampsPerGroup;
    for (int k = 0; k < n && k < LevelW; k++) begin
      if (mode_q[k] == MODE_ON) lv[k] = 1'b1;
      else if (mode_q[k] == MODE_SLOW || mode_q[k] == MODE_FAST) lv[k] = phase_q[k];
    end
    return lv;
  endfunction

  // Tick: prescaler wraps at the divisor, fast lamps in used groups always toggle
  function automatic void advance_blink();
    logic [DivW:0] next;
    logic [DivW:0] div;
    int n;
    div = (divisor_q == '0) ? 9'd1 : {1'b0, divisor_q};
    next = {1'b0, prescaler_q} + 9'd1;
    prescaler_q = (next >= div) ? '0 : next[DivW-1:0];
    n = groups_used() * LampsPerGroup;
    for (int k = 0; k < n; k++) begin
      if (mode_q[k] == MODE_FAST) phase_q[k] = ~phase_q[k];
      else if (mode_q[k] == MODE_SLOW && prescaler_q == '0) phase_q[k] = ~phase_q[k];
    end
  endfunction

  // Set: checks in priority order, then store mode and start the phase
  function automatic status_e apply_lamp_mode(logic [GroupW-1:0] grp,
                                               logic [LampIdxW-1:0] lamp,
                                               logic [ModeCodeW-1:0] mode);
    int k;
    if (groups_used() == 0) return ST_NO_GROUPS;
    if (int'(grp) >= groups_used()) return ST_BAD_GROUP;
    if (lamp == LampBad) return ST_BAD_LAMP;
    if (mode >= ModeBadLow) return ST_BAD_MODE;
    k = int'(grp) * LampsPerGroup + int'(lamp);
    mode_q[k] = lamp_mode_e'(mode[1:0]);
    phase_q[k] = (mode_q[k] == MODE_SLOW || mode_q[k] == MODE_FAST);
    return ST_OK;
  endfunction

  function automatic void predict_word(logic func, logic [GroupW-1:0] grp,
                                       logic [LampIdxW-1:0] lamp,
                                       logic [ModeCodeW-1:0] mode);
    lamp_result_t r;
    r.status = ST_OK;
    if (func == FuncTick) begin
      advance_blink();
      ticks_seen++;
    end else begin
      r.status = apply_lamp_mode(grp, lamp, mode);
      sets_seen++;
      if (r.status != ST_OK) sets_rejected++;
    end
    r.levels = lit_levels();
    expected_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on input accept, compare on output accept
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    lamp_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        predict_word(func_i, group_index_i, lamp_index_i, mode_code_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none actual status %0d levels %06h",
                   $time, status_o, lamp_levels_o);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          results_checked++;
          if (status_o !== want.status) begin
            $display("%0t ns: status mismatch, expected %0d actual %0d",
                     $time, want.status, status_o);
            error_count++;
          end
          if (lamp_levels_o !== want.levels) begin
            $display("%0t ns: lamp_levels mismatch, expected %06h actual %06h",
                     $time, want.levels, lamp_levels_o);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t ns: no handshake for %0d cycles", $time, IdleLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result side: random stall before each result word
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared tasks
  // ---------------------------------------------------------------------------
  // Send one word; valid stays high afterwards until the next gap or drain
  task automatic send_word(logic func, logic [GroupW-1:0] grp,
                           logic [LampIdxW-1:0] lamp, logic [ModeCodeW-1:0] mode);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= func;
    group_index_i <= grp;
    lamp_index_i  <= lamp;
    mode_code_i   <= mode;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(FuncTick, GroupW'($urandom), LampIdxW'($urandom), ModeCodeW'($urandom));
  endtask

  // Drop valid and wait until every result is back, plus pipeline latency
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    unique case (idx)
      CFG_GROUP_COUNT:  group_count_q = data[GroupW-1:0];
      CFG_SLOW_DIVISOR: divisor_q = data[DivW-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Group count with random upper data bits, which the register drops
  task automatic write_group_count(logic [GroupW-1:0] gc);
    write_reg(CFG_GROUP_COUNT, {4'($urandom), gc});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_after_reset();
    send_word(FuncTick, '1, '1, '1);
    send_word(FuncTick, '0, '0, '0);
  endtask

  task automatic test_lamp_modes();
    send_word(FuncSet, 4'd0, 2'd0, {1'b0, MODE_ON});
    send_word(FuncSet, 4'd7, 2'd2, {1'b0, MODE_FAST});
    send_word(FuncSet, 4'd3, 2'd1, {1'b0, MODE_SLOW});
    send_word(FuncSet, 4'd0, 2'd0, {1'b0, MODE_OFF});
    // rejected sets, checked in priority order
    send_word(FuncSet, 4'd8, 2'd0, {1'b0, MODE_ON});
    send_word(FuncSet, 4'd15, LampBad, ModeBadHigh);
    send_word(FuncSet, 4'd2, LampBad, ModeBadHigh);
    send_word(FuncSet, 4'd2, 2'd1, ModeBadLow);
    send_word(FuncSet, 4'd6, 2'd0, ModeBadHigh);
    // slow lamp toggles when the prescaler wraps at the reset divisor
    repeat (4) send_tick();
  endtask

  task automatic test_group_count();
    write_group_count(4'd0);
    send_word(FuncSet, 4'd0, 2'd0, {1'b0, MODE_ON});
    send_tick();
    write_group_count(4'd15);
    send_word(FuncSet, 4'd7, 2'd1, {1'b0, MODE_ON});
    // unused groups keep their state and read dark
    write_group_count(4'd2);
    send_tick();
    send_word(FuncSet, 4'd2, 2'd0, {1'b0, MODE_ON});
    write_group_count(4'd8);
    send_tick();
    // spare indexes hold no register
    write_reg(CFG_SPARE_2, 8'($urandom));
    write_reg(CFG_SPARE_3, 8'($urandom));
  endtask

  task automatic test_divisor();
    write_reg(CFG_SLOW_DIVISOR, 8'd255);
    repeat (4) send_tick();
    // prescaler now past the divisor: wraps on the next tick
    write_reg(CFG_SLOW_DIVISOR, 8'd3);
    send_tick();
    write_reg(CFG_SLOW_DIVISOR, 8'd0);
    send_tick();
    write_reg(CFG_SLOW_DIVISOR, 8'd1);
    send_tick();
  endtask

  task automatic random_phase(int count);
    int n;
    for (int i = 0; i < count; i++) begin
      n = groups_used();
      if ($urandom_range(0, 99) < 45) begin
        send_tick();
      end else if (n != 0 && $urandom_range(0, 9) < 8) begin
        send_word(FuncSet, GroupW'($urandom_range(0, n - 1)),
                  LampIdxW'($urandom_range(0, 2)), ModeCodeW'($urandom_range(0, 3)));
      end else begin
        send_word(FuncSet, GroupW'($urandom), LampIdxW'($urandom), ModeCodeW'($urandom));
      end
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_group_count(4'd8); write_reg(CFG_SLOW_DIVISOR, 8'd2); end
        1: begin
          write_group_count(GroupW'($urandom_range(1, 8)));
          write_reg(CFG_SLOW_DIVISOR, 8'($urandom_range(1, 6)));
        end
        2: begin
          write_group_count(GroupW'($urandom_range(9, 15)));
          write_reg(CFG_SLOW_DIVISOR, 8'd0);
        end
        3: begin
          write_group_count(GroupW'($urandom_range(0, 15)));
          write_reg(CFG_SLOW_DIVISOR, 8'd255);
        end
        4: begin
          write_group_count(4'd8);
          write_reg(CFG_SLOW_DIVISOR, 8'($urandom_range(1, 8)));
        end
        default: begin
          write_group_count(GroupW'($urandom_range(1, 15)));
          write_reg(CFG_SLOW_DIVISOR, 8'($urandom));
        end
      endcase
      no_idle = (ph == 1 || ph == 4);
      random_phase(75);
      no_idle = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < LampCount; k++) begin
      mode_q[k]  = MODE_OFF;
      phase_q[k] = 1'b0;
    end
    prescaler_q   = '0;
    group_count_q = GroupCountReset;
    divisor_q     = DivisorReset;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_after_reset();
    test_lamp_modes();
    test_group_count();
    test_divisor();
    test_random();

    drain();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d words: %0d ticks, %0d lamp sets (%0d rejected), %0d register writes",
             words_sent, ticks_seen, sets_seen, sets_rejected, cfg_writes);
    $display("Compared %0d results, %0d mismatches", results_checked, error_count);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (expected_q.size() != 0)
        $display("%0d expected results never arrived", expected_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
